[hdl/ssp_pkg.sv]
package ssp_pkg;

    localparam int MAX_PARAMS = 16;
    // cells 0 .. MAX_PARAMS+4 hold the bytes a packet check can look at
    localparam int WIN_CELLS  = MAX_PARAMS + 5;
    localparam int PTR_W      = $clog2(MAX_PARAMS);
    localparam int CNT_W      = $clog2(MAX_PARAMS + 1);

    localparam logic [1:0] CFG_SERVO_ID    = 2'd0;
    localparam logic [1:0] CFG_PARAM_COUNT = 2'd1;
    localparam logic [1:0] CFG_HEADER_BYTE = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_buffer;
    } ssp_in_t;

    typedef struct packed {
        logic       found;
        logic       param_valid;
        logic [7:0] param_byte;
        logic [5:0] param_index;
        logic       last;
    } ssp_out_t;

    typedef struct packed {
        logic       load;
        logic       found;
        logic       pvalid;
        logic [4:0] count;
    } ssp_load_t;

    typedef logic [MAX_PARAMS-1:0][7:0] ssp_params_t;

endpackage

[hdl/ssp_cell.sv]
module ssp_cell (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift_en,
    input  logic       clear,
    input  logic [7:0] new_byte,
    input  logic [7:0] prev_byte,
    input  logic [7:0] prev_sum,
    input  logic       prev_filled,
    output logic [7:0] byte_q,
    output logic [7:0] sum_q,
    output logic       filled_q
);
    logic [7:0] byte_reg, byte_next;
    logic [7:0] sum_reg, sum_next;
    logic       filled_reg, filled_next;

    // sum_reg holds the sum of the window from the newest byte down to this cell
    always_comb begin
        byte_next   = shift_en ? prev_byte : byte_reg;
        sum_next    = shift_en ? 8'(new_byte + prev_sum) : sum_reg;
        filled_next = clear ? 1'b0 : (shift_en ? prev_filled : filled_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= 1'b0;
        end else begin
            filled_reg <= filled_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        sum_reg  <= sum_next;
    end

    assign byte_q   = byte_reg;
    assign sum_q    = sum_reg;
    assign filled_q = filled_reg;

endmodule

[hdl/ssp_emit.sv]
module ssp_emit (
    input  logic                aclk,
    input  logic                aresetn,
    input  ssp_pkg::ssp_load_t  load,
    input  ssp_pkg::ssp_params_t params,
    output logic                empty,
    output logic                m_valid,
    input  logic                m_ready,
    output ssp_pkg::ssp_out_t   m_data
);
    import ssp_pkg::*;

    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [PTR_W-1:0] idx_reg, idx_next;
    logic             found_reg, found_next;
    logic             pvalid_reg, pvalid_next;
    ssp_params_t      pbuf_reg, pbuf_next;
    logic             m_valid_reg, m_valid_next;
    ssp_out_t         m_data_reg, m_data_next;
    logic             out_free;
    logic             move;

    assign out_free = !m_valid_reg || m_ready;
    assign move     = (rem_reg != '0) && out_free;

    always_comb begin
        rem_next    = rem_reg;
        ptr_next    = ptr_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        pvalid_next = pvalid_reg;
        pbuf_next   = pbuf_reg;
        if (load.load) begin
            rem_next    = load.pvalid ? CNT_W'(load.count) : CNT_W'(1);
            ptr_next    = PTR_W'(5'(load.count - 5'd1));
            idx_next    = '0;
            found_next  = load.found;
            pvalid_next = load.pvalid;
            pbuf_next   = params;
        end else if (move) begin
            rem_next = rem_reg - CNT_W'(1);
            ptr_next = ptr_reg - PTR_W'(1);
            idx_next = idx_reg + PTR_W'(1);
        end
    end

    // newest window cell is the last parameter, so read from the top down
    always_comb begin
        m_valid_next = move ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_data_next  = m_data_reg;
        if (move) begin
            m_data_next.found       = found_reg;
            m_data_next.param_valid = pvalid_reg;
            m_data_next.param_byte  = pvalid_reg ? pbuf_reg[ptr_reg] : 8'd0;
            m_data_next.param_index = pvalid_reg ? 6'(idx_reg) : 6'd0;
            m_data_next.last        = (rem_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        pvalid_reg <= pvalid_next;
        pbuf_reg   <= pbuf_next;
        m_data_reg <= m_data_next;
    end

    assign empty   = (rem_reg == '0);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_load_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        load.load |-> rem_reg == '0)
        else $error("report loaded while items still queued");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= CNT_W'(MAX_PARAMS))
        else $error("queued item count out of range");

    a_single_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.param_valid |-> m_data_reg.last)
        else $error("item without parameter is not the last of its report");

    a_load_count: assert property (@(posedge aclk) disable iff (!aresetn)
        load.load && load.pvalid |-> load.count != 5'd0 && load.count <= 5'(MAX_PARAMS))
        else $error("parameter report with bad count");

endmodule

[hdl/servo_status_packet_finder_top.sv]
// order: the byte that ends a report loads its queue, and the report's first item is then registered into the output
// throughput: one byte per cycle; a report of n items drains from its queue at one per cycle
//   while m_ready is high, and bytes of a buffer not yet matched wait while that queue is not empty
// reset: buffer search state, queue and output valid are cleared; the servo id is 1,
//   param_count 0 and header_byte 255; the byte window itself has no reset, only its fill bits
module servo_status_packet_finder_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ssp_pkg::ssp_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ssp_pkg::ssp_out_t m_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_wdata
);
    import ssp_pkg::*;

    logic [7:0] servo_id_reg, servo_id_next;
    logic [4:0] param_count_reg, param_count_next;
    logic [7:0] header_byte_reg, header_byte_next;
    logic       matched_reg, matched_next;

    logic [7:0]           win_q [WIN_CELLS];
    logic [7:0]           sum_q [WIN_CELLS];
    logic [WIN_CELLS-1:0] filled;
    logic [MAX_PARAMS:0]  ok;

    logic        acc;
    logic        shift_en;
    logic        clear;
    logic        ok_sel;
    logic        hit;
    logic        empty;
    logic [7:0]  b;
    ssp_load_t   load;
    ssp_params_t params;

    always_comb begin
        servo_id_next    = servo_id_reg;
        param_count_next = param_count_reg;
        header_byte_next = header_byte_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_SERVO_ID:    servo_id_next    = cfg_wdata;
                CFG_PARAM_COUNT: param_count_next = cfg_wdata[4:0];
                CFG_HEADER_BYTE: header_byte_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    assign b        = s_data.rx_byte;
    assign s_ready  = matched_reg || empty;
    assign acc      = s_valid && s_ready;
    assign shift_en = acc && !matched_reg;
    assign clear    = acc && s_data.end_of_buffer;

    genvar i;
    generate
        for (i = 0; i < WIN_CELLS; i++) begin : g_cell
            if (i == 0) begin : g_first
                ssp_cell u_cell (
                    .aclk(aclk), .aresetn(aresetn), .shift_en(shift_en), .clear(clear),
                    .new_byte(b), .prev_byte(b), .prev_sum(8'd0), .prev_filled(1'b1),
                    .byte_q(win_q[i]), .sum_q(sum_q[i]), .filled_q(filled[i])
                );
            end else begin : g_rest
                ssp_cell u_cell (
                    .aclk(aclk), .aresetn(aresetn), .shift_en(shift_en), .clear(clear),
                    .new_byte(b), .prev_byte(win_q[i-1]), .prev_sum(sum_q[i-1]),
                    .prev_filled(filled[i-1]),
                    .byte_q(win_q[i]), .sum_q(sum_q[i]), .filled_q(filled[i])
                );
            end
        end

        // check for each count against the window as it is before the new byte goes in
        for (i = 0; i <= MAX_PARAMS; i++) begin : g_ok
            assign ok[i] = filled[i+4]
                        && win_q[i+4] == header_byte_reg
                        && win_q[i+3] == header_byte_reg
                        && win_q[i+2] == servo_id_reg
                        && win_q[i+1] == 8'(i + 2)
                        && win_q[i]   == 8'd0
                        && sum_q[i+2] == ~b;
        end

        for (i = 0; i < MAX_PARAMS; i++) begin : g_param
            assign params[i] = win_q[i];
        end
    endgenerate

    assign ok_sel = (param_count_reg <= 5'(MAX_PARAMS)) ? ok[param_count_reg] : 1'b0;
    assign hit    = shift_en && ok_sel;

    always_comb begin
        load.load    = shift_en && (ok_sel || s_data.end_of_buffer);
        load.found   = hit;
        load.pvalid  = hit && (param_count_reg != 5'd0);
        load.count   = param_count_reg;
        matched_next = clear ? 1'b0 : (hit ? 1'b1 : matched_reg);
    end

    ssp_emit u_emit (
        .aclk(aclk), .aresetn(aresetn), .load(load), .params(params), .empty(empty),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            servo_id_reg    <= 8'd1;
            param_count_reg <= 5'd0;
            header_byte_reg <= 8'd255;
            matched_reg     <= 1'b0;
        end else begin
            servo_id_reg    <= servo_id_next;
            param_count_reg <= param_count_next;
            header_byte_reg <= header_byte_next;
            matched_reg     <= matched_next;
        end
    end

    a_eob_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        clear |=> !matched_reg && filled == '0)
        else $error("end of buffer did not clear the search state");

    a_hit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        hit && !s_data.end_of_buffer |=> matched_reg)
        else $error("match not recorded");

    a_window_still: assert property (@(posedge aclk) disable iff (!aresetn)
        !shift_en && !clear |=> $stable(filled))
        else $error("window moved without a new item");

endmodule
